FILE: src/shfp_pkg.sv
`timescale 1ns / 1ps

package shfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  localparam int WORD_COUNT_DEF = 12;

  // two payload banks, one per queue slot
  localparam int QUEUE_DEPTH = 2;
  localparam int BANK_W      = $clog2(QUEUE_DEPTH);

  typedef logic [BANK_W-1:0] bank_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

FILE: src/shfp_if.sv
`timescale 1ns / 1ps

interface shfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface shfp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  channel;
  logic [15:0] position;
  logic        last_word;

  modport source (output valid, output channel, output position, output last_word,
                  input ready);
  modport sink   (input valid, input channel, input position, input last_word,
                  output ready);
endinterface

FILE: src/shfp_queue.sv
`timescale 1ns / 1ps

module shfp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  shfp_pkg::bank_t     push_bank_i,
  input  logic                pop_i,
  output shfp_pkg::bank_t     head_bank_o,
  output shfp_pkg::queue_stat_t stat_o
);
  import shfp_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  bank_t            ent_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_bank_i;
    end
  end

  assign head_bank_o  = ent_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

FILE: src/shfp_front.sv
`timescale 1ns / 1ps

module shfp_front #(
  parameter int WORD_COUNT = shfp_pkg::WORD_COUNT_DEF,
  parameter int WIDX       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1,
  parameter int AW         = shfp_pkg::BANK_W + WIDX
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  shfp_in_if.sink               in_i,
  input  shfp_pkg::queue_stat_t q_stat_i,
  output logic                  push_o,
  output shfp_pkg::bank_t       push_bank_o,
  output logic                  wr_en_o,
  output logic [AW-1:0]         wr_addr_o,
  output logic [15:0]           wr_data_o
);
  import shfp_pkg::*;

  localparam int CW = $clog2(2 * WORD_COUNT + 1);

  typedef enum logic [3:0] {
    PH_HUNT1 = 4'b0001,
    PH_HUNT2 = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_CHECK = 4'b1000
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    sum_q, sum_d;
  logic [7:0]    lo_q;
  bank_t         wr_bank_q, wr_bank_d;
  logic          acc;
  logic [7:0]    b;

  // payload must wait while both banks hold frames not yet drained
  assign in_i.ready = !((phase_q == PH_DATA) && q_stat_i.full);
  assign acc        = in_i.valid && in_i.ready;
  assign b          = in_i.rx_byte;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    wr_bank_d = wr_bank_q;
    push_o    = 1'b0;
    wr_en_o   = 1'b0;
    if (acc) begin
      unique case (phase_q)
        PH_HUNT1: begin
          if (b == SYNC_FIRST) phase_d = PH_HUNT2;
        end
        PH_HUNT2: begin
          if (b == SYNC_SECOND) begin
            phase_d = PH_DATA;
            cnt_d   = '0;
            sum_d   = '0;
          end else begin
            phase_d = PH_HUNT1;
          end
        end
        PH_DATA: begin
          wr_en_o = cnt_q[0];
          cnt_d   = cnt_q + CW'(1);
          sum_d   = sum_q + b;
          if (cnt_q == CW'(2 * WORD_COUNT - 1)) phase_d = PH_CHECK;
        end
        PH_CHECK: begin
          if (b == sum_q) begin
            push_o    = 1'b1;
            wr_bank_d = wr_bank_q + BANK_W'(1);
          end
          phase_d = PH_HUNT1;
        end
        default: phase_d = PH_HUNT1;
      endcase
    end
  end

  assign push_bank_o = wr_bank_q;
  assign wr_addr_o   = {wr_bank_q, WIDX'(cnt_q >> 1)};
  assign wr_data_o   = {b, lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT1;
      cnt_q     <= '0;
      sum_q     <= '0;
      wr_bank_q <= '0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      sum_q     <= sum_d;
      wr_bank_q <= wr_bank_d;
    end
  end

  // low byte of a word waits here until its high byte arrives
  always_ff @(posedge clk_i) begin
    if (acc && (phase_q == PH_DATA) && !cnt_q[0]) begin
      lo_q <= b;
    end
  end

endmodule

FILE: src/shfp_back.sv
`timescale 1ns / 1ps

module shfp_back #(
  parameter int WORD_COUNT = shfp_pkg::WORD_COUNT_DEF,
  parameter int WIDX       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1,
  parameter int AW         = shfp_pkg::BANK_W + WIDX
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic [15:0]           wr_data_i,
  input  shfp_pkg::queue_stat_t q_stat_i,
  input  shfp_pkg::bank_t       head_bank_i,
  output logic                  pop_o,
  shfp_out_if.source            out_o
);
  import shfp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_SHOW  = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [WIDX-1:0] idx_q, idx_d;
  logic [15:0]     mem_q [2**AW];
  logic [15:0]     rd_q;
  logic            last;

  assign last = (idx_q == WIDX'(WORD_COUNT - 1));

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          idx_d   = '0;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_SHOW;
      ST_SHOW: begin
        if (out_o.ready) begin
          if (last) begin
            pop_o   = 1'b1;
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + WIDX'(1);
            state_d = ST_FETCH;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // bank at the queue head stays put until its last word is taken
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[{head_bank_i, idx_q}];
  end

  assign out_o.valid     = (state_q == ST_SHOW);
  assign out_o.channel   = 4'(idx_q);
  assign out_o.position  = rd_q;
  assign out_o.last_word = last;

endmodule

FILE: src/sync_header_frame_parser_top.sv
`timescale 1ns / 1ps

// Frame parser for a byte stream: hunts for the sync pair AA 55, stores
// 2*WORD_COUNT payload bytes, checks the following byte against their 8-bit
// wrapping sum and, on a match, emits WORD_COUNT words (low byte first) with
// their index, the final one flagged by last_word. Bytes are taken one per
// cycle; the input stalls only on a payload byte while two checked frames
// are still waiting to be drained, since the payload lives in two banks of
// one write / one read memory, one bank per slot of the frame queue. Each
// word passes through a FETCH state (registered memory read) and a SHOW
// state (word offered to the sink, held while the sink holds off); after
// the last word the output side returns to IDLE before the next frame.
module sync_header_frame_parser_top #(
  parameter int WORD_COUNT = shfp_pkg::WORD_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  shfp_in_if.sink    in_i,
  shfp_out_if.source out_o
);
  import shfp_pkg::*;

  localparam int WIDX = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int AW   = BANK_W + WIDX;

  queue_stat_t   q_stat;
  logic          push, pop;
  bank_t         push_bank, head_bank;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;

  shfp_front #(
    .WORD_COUNT (WORD_COUNT),
    .WIDX       (WIDX),
    .AW         (AW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_bank_o (push_bank),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  shfp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_bank_i (push_bank),
    .pop_i       (pop),
    .head_bank_o (head_bank),
    .stat_o      (q_stat)
  );

  shfp_back #(
    .WORD_COUNT (WORD_COUNT),
    .WIDX       (WIDX),
    .AW         (AW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .q_stat_i    (q_stat),
    .head_bank_i (head_bank),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

FILE: src/shfp_checker.sv
`timescale 1ns / 1ps

module shfp_checker #(
  parameter int WORD_COUNT = shfp_pkg::WORD_COUNT_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  out_channel_i,
  input logic        out_last_word_i
);

  logic out_acc;
  assign out_acc = out_valid_i && out_ready_i;

  // a stalled result is not withdrawn
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // the flagged word is always the final index of the frame
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_word_i |-> out_channel_i == 4'(WORD_COUNT - 1))
    else $error("last_word on wrong channel");

  // words of one frame come in index order, with a fetch state between them
  a_next_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_last_word_i |=> !out_valid_i ##1
      (out_valid_i && out_channel_i == 4'($past(out_channel_i, 2) + 4'd1)))
    else $error("word order broken within frame");

  // after the final transfer the output side goes idle before the next frame
  a_frame_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_last_word_i |=> !out_valid_i)
    else $error("no idle cycle after last word");

endmodule

bind sync_header_frame_parser_top shfp_checker #(
  .WORD_COUNT (WORD_COUNT)
) u_shfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_channel_i   (out_o.channel),
  .out_last_word_i (out_o.last_word)
);

FILE: dv/shfp_frame_checker.sv
`timescale 1ns / 1ps

module shfp_frame_checker #(
  parameter int WORD_COUNT = shfp_pkg::WORD_COUNT_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  shfp_in_if   byte_i,
  shfp_out_if  word_i,
  output int   fail_count_o,
  output int   pending_o
);

  import shfp_pkg::*;

  localparam int PAYLOAD_LEN = 2 * WORD_COUNT;

  typedef enum logic [1:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    TAKE_PAYLOAD,
    TAKE_SUM
  } parse_phase_e;

  typedef struct packed {
    logic [3:0]  channel;
    logic [15:0] position;
    logic        last_word;
  } frame_word_t;

  parse_phase_e phase_q;
  logic [7:0]   payload_q [PAYLOAD_LEN];
  int unsigned  payload_cnt_q;
  logic [7:0]   payload_sum_q;
  frame_word_t  words_due[$];
  int           mismatches = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // advance the frame parser by one byte, queueing the decoded words of a good frame
  task automatic take_byte(input logic [7:0] b);
    frame_word_t w;
    case (phase_q)
      HUNT_FIRST: begin
        if (b == SYNC_FIRST) phase_q = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        if (b == SYNC_SECOND) begin
          phase_q       = TAKE_PAYLOAD;
          payload_cnt_q = 0;
          payload_sum_q = '0;
        end else begin
          // the offending byte is not retried as a first sync byte
          phase_q = HUNT_FIRST;
        end
      end
      TAKE_PAYLOAD: begin
        payload_q[payload_cnt_q] = b;
        payload_cnt_q++;
        payload_sum_q += b;
        if (payload_cnt_q >= PAYLOAD_LEN) phase_q = TAKE_SUM;
      end
      default: begin
        if (b == payload_sum_q) begin
          for (int i = 0; i < WORD_COUNT; i++) begin
            w.channel   = 4'(i);
            w.position  = {payload_q[2*i+1], payload_q[2*i]};
            w.last_word = (i == WORD_COUNT - 1);
            words_due.push_back(w);
          end
        end
        phase_q = HUNT_FIRST;
      end
    endcase
  endtask

  task automatic check_word();
    frame_word_t want;
    if (words_due.size() == 0) begin
      report_mismatch($sformatf("unexpected word channel %0d position %h last %b",
                                word_i.channel, word_i.position, word_i.last_word));
    end else begin
      want = words_due.pop_front();
      if (word_i.channel !== want.channel)
        report_mismatch($sformatf("channel got %0d want %0d", word_i.channel, want.channel));
      if (word_i.position !== want.position)
        report_mismatch($sformatf("position got %h want %h on channel %0d",
                                  word_i.position, want.position, want.channel));
      if (word_i.last_word !== want.last_word)
        report_mismatch($sformatf("last_word got %b want %b on channel %0d",
                                  word_i.last_word, want.last_word, want.channel));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       = HUNT_FIRST;
      payload_cnt_q = 0;
      payload_sum_q = '0;
      words_due.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      // a word leaving now can never belong to a frame whose checksum arrives now
      if (word_i.valid && word_i.ready) check_word();
      if (byte_i.valid && byte_i.ready) take_byte(byte_i.rx_byte);
      pending_o    <= words_due.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  import shfp_pkg::*;

  localparam int WORD_COUNT   = WORD_COUNT_DEF;
  localparam int PAYLOAD_LEN  = 2 * WORD_COUNT;
  localparam int RANDOM_BYTES = 470;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int {
    FILL_RANDOM,
    FILL_ONES,
    FILL_ZEROS,
    FILL_SYNC,
    FILL_MIXED
  } fill_e;

  logic clk;
  logic rst_n;
  int   cycles = 0;
  int   fail_count;
  int   pending;
  bit   steady_in;
  int   random_bytes;
  int   kind;
  int   noise_len;
  logic [7:0] second;

  shfp_in_if  byte_if ();
  shfp_out_if word_if ();

  sync_header_frame_parser_top #(
    .WORD_COUNT(WORD_COUNT)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (byte_if),
    .out_o (word_if)
  );

  shfp_frame_checker #(
    .WORD_COUNT(WORD_COUNT)
  ) frame_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .byte_i      (byte_if),
    .word_i      (word_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sync_header_frame_parser_top verification failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (r < 55) gap = 0;
    else if (r < 88) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 40);
    return gap;
  endfunction

  // output side back-pressure
  initial begin
    int gap;
    word_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        word_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      word_if.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = steady_in ? 0 : pick_gap();
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_if.valid   <= 1'b1;
    byte_if.rx_byte <= b;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
  endtask

  task automatic send_frame(input fill_e fill, input bit sum_ok);
    logic [7:0] body [PAYLOAD_LEN];
    logic [7:0] sum;
    sum = '0;
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      case (fill)
        FILL_ONES:  body[i] = 8'hFF;
        FILL_ZEROS: body[i] = 8'h00;
        FILL_SYNC:  body[i] = $urandom_range(0, 1) ? SYNC_FIRST : SYNC_SECOND;
        FILL_MIXED: begin
          case (i % 4)
            0: body[i] = 8'h00;
            1: body[i] = 8'hFF;
            2: body[i] = SYNC_FIRST;
            default: body[i] = SYNC_SECOND;
          endcase
        end
        default: body[i] = 8'($urandom);
      endcase
      sum += body[i];
    end
    if (!sum_ok) sum += 8'($urandom_range(1, 255));
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    for (int i = 0; i < PAYLOAD_LEN; i++) send_byte(body[i]);
    send_byte(sum);
  endtask

  function automatic fill_e pick_fill();
    int r;
    fill_e f;
    r = $urandom_range(0, 9);
    if (r == 0) f = FILL_ONES;
    else if (r == 1) f = FILL_ZEROS;
    else if (r == 2) f = FILL_SYNC;
    else f = FILL_RANDOM;
    return f;
  endfunction

  initial begin
    byte_if.valid   <= 1'b0;
    byte_if.rx_byte <= '0;
    rst_n           <= 1'b0;
    steady_in        = 1'b0;
    random_bytes     = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hunting noise, a doubled first sync byte, a broken sync pair
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_SECOND);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(SYNC_FIRST);
    send_byte(8'h00);
    // good frame with extreme bytes and sync bytes inside the payload
    send_frame(FILL_MIXED, 1'b1);
    random_bytes = 8 + PAYLOAD_LEN + 3;

    while (random_bytes < RANDOM_BYTES) begin
      steady_in = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        send_frame(pick_fill(), 1'b1);
        random_bytes += PAYLOAD_LEN + 3;
      end else if (kind == 7) begin
        send_frame(pick_fill(), 1'b0);
        random_bytes += PAYLOAD_LEN + 3;
      end else if (kind == 8) begin
        second = $urandom_range(0, 1) ? SYNC_FIRST : 8'($urandom);
        if (second == SYNC_SECOND) second = 8'h54;
        send_byte(SYNC_FIRST);
        send_byte(second);
        random_bytes += 2;
      end else begin
        noise_len = $urandom_range(1, 4);
        repeat (noise_len) send_byte(8'($urandom));
        random_bytes += noise_len;
      end
    end
    byte_if.valid <= 1'b0;

    // let the last checksum transfer reach the expectation count
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4 * WORD_COUNT + 16) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("sync_header_frame_parser_top verification clean");
    end else begin
      $display("sync_header_frame_parser_top verification failed");
    end
    $finish;
  end

endmodule
